@@ design/blt_pkg.sv @@
package blt_pkg;

  // Field widths fixed by the item formats.
  localparam int OP_W        = 3;
  localparam int VALUE_W     = 32;
  localparam int INDEX_W     = 8;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 11;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DELETE     = 3'd4,
    OP_DUMP       = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_NOIDX = 2'd3
  } status_e;

  // Work handed from the classifier to the executor.
  typedef enum logic [1:0] {
    CMD_REPORT = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        index;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] value_res;
    logic [COUNT_W-1:0]        count;
    logic                      last;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e           kind;
    status_e             status;
    logic [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]  addr;
    logic [COUNT_W-1:0]  steps;
    logic [COUNT_W-1:0]  count;
  } cmd_t;

endpackage

@@ design/blt_front.sv @@
module blt_front import blt_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;

  logic [CW-1:0] count, count_next;
  logic [AW-1:0] front_pos, front_pos_next;
  logic          full, empty, accept;
  logic [CW-1:0] idx;

  // Store slot of a list position, wrapping around the circular store.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] pos);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(pos);
    if (sum >= SW'(CAPACITY)) begin
      sum = sum - SW'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    return (s == AW'(CAPACITY - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
    return (s == '0) ? AW'(CAPACITY - 1) : s - 1'b1;
  endfunction

  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  assign idx       = CW'(in_data.index);
  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign accept    = in_valid && cmd_ready;

  // Classify the item against the shadow count and front slot.
  always_comb begin
    cmd            = '0;
    cmd.kind       = CMD_REPORT;
    cmd.status     = ST_DONE;
    cmd.value      = in_data.value;
    count_next     = count;
    front_pos_next = front_pos;
    unique case (in_data.operation)
      OP_PUSH_FRONT: begin
        if (full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.kind       = CMD_WRITE;
          front_pos_next = slot_dec(front_pos);
          cmd.addr       = COUNT_W'(front_pos_next);
          count_next     = count + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.kind   = CMD_WRITE;
          cmd.addr   = COUNT_W'(slot_of(front_pos, count));
          count_next = count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          cmd.status = ST_EMPTY;
        end else begin
          cmd.kind       = CMD_REMOVE;
          cmd.addr       = COUNT_W'(front_pos);
          count_next     = count - 1'b1;
          front_pos_next = (count == CW'(1)) ? '0 : slot_inc(front_pos);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          cmd.status = ST_EMPTY;
        end else begin
          cmd.kind       = CMD_REMOVE;
          cmd.addr       = COUNT_W'(slot_of(front_pos, count - 1'b1));
          count_next     = count - 1'b1;
          front_pos_next = (count == CW'(1)) ? '0 : front_pos;
        end
      end
      OP_DELETE: begin
        if (empty) begin
          cmd.status = ST_EMPTY;
        end else if (COUNT_W'(in_data.index) >= COUNT_W'(count)) begin
          cmd.status = ST_NOIDX;
        end else begin
          cmd.kind   = CMD_REMOVE;
          cmd.addr   = COUNT_W'(slot_of(front_pos, idx));
          count_next = count - 1'b1;
          // The front element goes by moving the front slot, with no shifting.
          if (idx == '0) begin
            front_pos_next = (count == CW'(1)) ? '0 : slot_inc(front_pos);
          end else begin
            cmd.steps = COUNT_W'(count - 1'b1 - idx);
          end
        end
      end
      OP_DUMP: begin
        if (empty) begin
          cmd.status = ST_EMPTY;
        end else begin
          cmd.kind  = CMD_DUMP;
          cmd.addr  = COUNT_W'(front_pos);
          cmd.steps = COUNT_W'(count);
        end
      end
      default: begin
        cmd.status = ST_DONE;
      end
    endcase
    cmd.count = COUNT_W'(count_next);
  end

  // Shadow list state advances as each item is classified.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      front_pos <= '0;
    end else if (accept) begin
      count     <= count_next;
      front_pos <= front_pos_next;
    end
  end

endmodule

@@ design/blt_queue.sv @@
module blt_queue import blt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] fill;
  logic          do_push, do_pop;

  assign push_ready = (fill != NW'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

@@ design/blt_back.sv @@
module blt_back import blt_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FIRST = 5'b00010,
    S_SHIFT = 5'b00100,
    S_EMIT  = 5'b01000,
    S_DUMP  = 5'b10000
  } state_t;

  state_t               state, state_next;
  logic [CW-1:0]        steps, steps_next;
  logic [AW-1:0]        wptr, wptr_next;
  logic [AW-1:0]        rptr, rptr_next;
  logic [COUNT_W-1:0]   count, count_next;
  logic [VALUE_W-1:0]   removed, removed_next;

  logic [VALUE_W-1:0]   mem [CAPACITY];
  logic [VALUE_W-1:0]   rdata;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [VALUE_W-1:0]   mem_wdata;

  logic                 can_emit, emit;
  out_item_t            emit_data;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    return (s == AW'(CAPACITY - 1)) ? '0 : s + 1'b1;
  endfunction

  assign can_emit = !out_valid || out_ready;

  // Sequencer: one memory read and one write per cycle at most.
  always_comb begin
    state_next   = state;
    steps_next   = steps;
    wptr_next    = wptr;
    rptr_next    = rptr;
    count_next   = count;
    removed_next = removed;
    cmd_ready    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = wptr;
    mem_wdata    = rdata;
    mem_re       = 1'b0;
    mem_raddr    = rptr;
    emit         = 1'b0;
    emit_data    = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && can_emit) begin
          cmd_ready  = 1'b1;
          count_next = cmd.count;
          steps_next = CW'(cmd.steps);
          case (cmd.kind)
            CMD_WRITE: begin
              mem_we    = 1'b1;
              mem_waddr = AW'(cmd.addr);
              mem_wdata = cmd.value;
              emit      = 1'b1;
              emit_data = '{status: ST_DONE, value_res: '0, count: cmd.count, last: 1'b1};
            end
            CMD_REMOVE: begin
              mem_re     = 1'b1;
              mem_raddr  = AW'(cmd.addr);
              wptr_next  = AW'(cmd.addr);
              state_next = S_FIRST;
            end
            CMD_DUMP: begin
              mem_re     = 1'b1;
              mem_raddr  = AW'(cmd.addr);
              rptr_next  = AW'(cmd.addr);
              state_next = S_DUMP;
            end
            default: begin
              emit      = 1'b1;
              emit_data = '{status: cmd.status, value_res: '0, count: cmd.count,
                            last: 1'b1};
            end
          endcase
        end
      end
      S_FIRST: begin
        // The removed element arrives; start closing the gap if needed.
        removed_next = rdata;
        if (steps != '0) begin
          mem_re     = 1'b1;
          mem_raddr  = slot_inc(wptr);
          rptr_next  = slot_inc(wptr);
          state_next = S_SHIFT;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_SHIFT: begin
        // Move the element just read one slot toward the front.
        mem_we     = 1'b1;
        mem_waddr  = wptr;
        mem_wdata  = rdata;
        wptr_next  = rptr;
        steps_next = steps - 1'b1;
        if (steps > CW'(1)) begin
          mem_re    = 1'b1;
          mem_raddr = slot_inc(rptr);
          rptr_next = slot_inc(rptr);
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (can_emit) begin
          emit       = 1'b1;
          emit_data  = '{status: ST_DONE, value_res: removed, count: count, last: 1'b1};
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        // Read data holds until the next read, so a stalled output loses nothing.
        if (can_emit) begin
          emit       = 1'b1;
          emit_data  = '{status: ST_DONE, value_res: rdata, count: count,
                         last: (steps == CW'(1))};
          steps_next = steps - 1'b1;
          if (steps > CW'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = slot_inc(rptr);
            rptr_next = slot_inc(rptr);
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and output payload.
  always_ff @(posedge clk) begin
    steps   <= steps_next;
    wptr    <= wptr_next;
    rptr    <= rptr_next;
    count   <= count_next;
    removed <= removed_next;
    if (emit) begin
      out_data <= emit_data;
    end
  end

  // Element store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

endmodule

@@ design/bounded_list_with_tail_unit.sv @@
// Ordered list of up to CAPACITY signed 32-bit values held in a circular
// store, with push and pop at both ends, delete at a zero-based index and a
// front-to-back dump. The front stage classifies each item against its own
// copy of the count and front slot and takes a new item every cycle while the
// two-entry command queue has room. The back stage carries the commands out
// through the single-port-read element memory and gives one result per cycle
// at best: a push or a rejected request is answered from idle; a pop at
// either end or a delete reads the removed element first, and a delete at
// index i above zero moves the count - 1 - i elements behind it one slot
// toward the front before the result; a dump reads the elements front to
// back, one result each. Reading an element that was never written gives an
// undefined value; the list itself needs no clearing after reset.
module bounded_list_with_tail_unit import blt_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cmd_t q_in, q_out;
  logic q_in_valid, q_in_ready, q_out_valid, q_out_ready;

  // Classifier.
  blt_front #(
    .CAPACITY(CAPACITY)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cmd_valid(q_in_valid),
    .cmd_ready(q_in_ready),
    .cmd      (q_in)
  );

  // Command queue between the two stages.
  blt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(q_in_valid),
    .push_ready(q_in_ready),
    .push_data (q_in),
    .pop_valid (q_out_valid),
    .pop_ready (q_out_ready),
    .pop_data  (q_out)
  );

  // Executor and element store.
  blt_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(q_out_valid),
    .cmd_ready(q_out_ready),
    .cmd      (q_out),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

@@ tb/blt_list_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the list unit, keeps its own copy of the list,
// works out the results of every accepted request and compares each result
// transfer with the oldest one still awaited.
module blt_list_checker import blt_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatch_total,
  output int        results_outstanding
);

  // Shadow copy of the list: circular slots addressed from the front slot.
  logic signed [VALUE_W-1:0] list_slots [CAPACITY];
  int unsigned               list_len;
  int unsigned               list_head;

  out_item_t awaited_results [$];
  int        mismatches;

  function automatic int unsigned slot_at(input int unsigned pos);
    return (list_head + pos) % CAPACITY;
  endfunction

  // Queues one result, carrying the element count after the operation.
  function automatic void note_result(input status_e st,
                                      input logic signed [VALUE_W-1:0] val,
                                      input logic fin);
    out_item_t r;
    r.status    = st;
    r.value_res = val;
    r.count     = list_len[COUNT_W-1:0];
    r.last      = fin;
    awaited_results.insert(awaited_results.size(), r);
  endfunction

  // Removes the element at a position, closing the gap toward the front.
  function automatic logic signed [VALUE_W-1:0] take_element(input int unsigned pos);
    logic signed [VALUE_W-1:0] v;
    int unsigned               i;
    v = list_slots[slot_at(pos)];
    if (pos == 0) begin
      list_head = slot_at(1);
    end else begin
      for (i = pos; i + 1 < list_len; i++) begin
        list_slots[slot_at(i)] = list_slots[slot_at(i + 1)];
      end
    end
    list_len--;
    if (list_len == 0) begin
      list_head = 0;
    end
    return v;
  endfunction

  // Applies one request to the shadow list and queues what it should give.
  function automatic void apply_list_op(input in_item_t item);
    int unsigned i;
    case (item.operation)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (list_len >= CAPACITY) begin
          note_result(ST_FULL, '0, 1'b1);
        end else begin
          if (item.operation == OP_PUSH_FRONT) begin
            list_head = (list_head + CAPACITY - 1) % CAPACITY;
            list_slots[list_head] = item.value;
          end else begin
            list_slots[slot_at(list_len)] = item.value;
          end
          list_len++;
          note_result(ST_DONE, '0, 1'b1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (list_len == 0) begin
          note_result(ST_EMPTY, '0, 1'b1);
        end else if (item.operation == OP_POP_FRONT) begin
          note_result(ST_DONE, take_element(0), 1'b1);
        end else begin
          note_result(ST_DONE, take_element(list_len - 1), 1'b1);
        end
      end
      OP_DELETE: begin
        if (list_len == 0) begin
          note_result(ST_EMPTY, '0, 1'b1);
        end else if (item.index >= list_len) begin
          note_result(ST_NOIDX, '0, 1'b1);
        end else begin
          note_result(ST_DONE, take_element(item.index), 1'b1);
        end
      end
      OP_DUMP: begin
        if (list_len == 0) begin
          note_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < list_len; i++) begin
            note_result(ST_DONE, list_slots[slot_at(i)], i + 1 == list_len);
          end
        end
      end
      // Spare operation codes leave the list alone and just report the count.
      default: begin
        note_result(ST_DONE, '0, 1'b1);
      end
    endcase
  endfunction

  // Result transfers are checked before the request of the same edge is applied;
  // a result can never come from a request accepted at that very edge.
  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst) begin
      list_len   = 0;
      list_head  = 0;
      mismatches = 0;
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with no result awaited: status %0d value_res %0d count %0d",
                 out_data.status, out_data.value_res, out_data.count);
          mismatches++;
        end else begin
          exp_item = awaited_results[0];
          awaited_results.delete(0);
          if (out_data.status !== exp_item.status) begin
            $error("status: expected %0d, got %0d", exp_item.status, out_data.status);
            mismatches++;
          end
          if (out_data.value_res !== exp_item.value_res) begin
            $error("value_res: expected %0d, got %0d", exp_item.value_res,
                   out_data.value_res);
            mismatches++;
          end
          if (out_data.count !== exp_item.count) begin
            $error("count: expected %0d, got %0d", exp_item.count, out_data.count);
            mismatches++;
          end
          if (out_data.last !== exp_item.last) begin
            $error("last: expected %0d, got %0d", exp_item.last, out_data.last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_list_op(in_data);
      end
    end
    mismatch_total      <= mismatches;
    results_outstanding <= awaited_results.size();
  end

endmodule

@@ tb/tb_bounded_list_with_tail_unit.sv @@
`timescale 1ns / 1ps

// Drives request and result channels of the list unit with directed and
// random traffic; the checker beside the block does all the comparing.
module tb_bounded_list_with_tail_unit;
  import blt_pkg::*;

  localparam int CAPACITY = 32;

  // Operation codes that the block has no use for.
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int mismatch_total;
  int results_outstanding;
  bit sender_burst = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bounded_list_with_tail_unit #(.CAPACITY(CAPACITY)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  blt_list_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data             (in_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_data            (out_data),
    .mismatch_total      (mismatch_total),
    .results_outstanding (results_outstanding)
  );

  // Mostly back to back or short pauses, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Offers one request and holds it until the transfer happens.
  task automatic send_item(input logic [OP_W-1:0] op,
                           input logic signed [VALUE_W-1:0] val,
                           input logic [INDEX_W-1:0] idx);
    int gap;
    gap = sender_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{operation: op, value: val, index: idx};
    do @(posedge clk); while (!in_ready);
  endtask

  // Pushes only, at random ends, so the list is sure to run full.
  task automatic random_fill(input int n);
    repeat (n) begin
      send_item($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, rand_value(),
                INDEX_W'($urandom()));
    end
  endtask

  // Weighted mix of all operations; indexes mostly near the live range.
  task automatic random_items(input int n, input int w_push, input int w_pop,
                              input int w_del, input int w_dump, input int w_spare);
    int                   r;
    logic [OP_W-1:0]      op;
    logic [INDEX_W-1:0]   idx;
    repeat (n) begin
      r = $urandom_range(0, w_push + w_pop + w_del + w_dump + w_spare - 1);
      if (r < w_push) begin
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else if (r < w_push + w_pop) begin
        op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      end else if (r < w_push + w_pop + w_del) begin
        op = OP_DELETE;
      end else if (r < w_push + w_pop + w_del + w_dump) begin
        op = OP_DUMP;
      end else begin
        op = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
      end
      idx = ($urandom_range(0, 99) < 85) ? INDEX_W'($urandom_range(0, CAPACITY + 1))
                                         : INDEX_W'($urandom_range(0, 255));
      send_item(op, rand_value(), idx);
    end
  endtask

  // Request side and verdict.
  initial begin
    int guard;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Everything on an empty list first.
    send_item(OP_DUMP,       '0, '0);
    send_item(OP_POP_FRONT,  '0, '0);
    send_item(OP_POP_BACK,   '0, '0);
    send_item(OP_DELETE,     '0, '0);
    // Popping the only element from either end must empty the list.
    send_item(OP_PUSH_FRONT, VAL_MAX, '0);
    send_item(OP_POP_BACK,   '0, '0);
    send_item(OP_PUSH_BACK,  VAL_MIN, '0);
    send_item(OP_POP_FRONT,  '0, '0);
    // Build 0, 1, -1 and remove the second element by index.
    send_item(OP_PUSH_BACK,  32'sd1, '0);
    send_item(OP_PUSH_BACK,  '1, '0);
    send_item(OP_PUSH_FRONT, '0, '0);
    send_item(OP_DUMP,       '0, '0);
    send_item(OP_DELETE,     '0, 8'd1);
    send_item(OP_DELETE,     '0, 8'd255);
    send_item(OP_DELETE,     '0, 8'd2);
    send_item(OP_SPARE_6,    VAL_MAX, 8'd255);
    send_item(OP_SPARE_7,    '0, '0);
    send_item(OP_PUSH_FRONT, 32'shA5A5_A5A5, '0);
    send_item(OP_PUSH_BACK,  32'sh5A5A_5A5A, '0);
    // Delete the tail, then the head, through the index path.
    send_item(OP_DELETE,     '0, 8'd3);
    send_item(OP_DELETE,     '0, 8'd0);
    send_item(OP_DUMP,       '0, '0);
    send_item(OP_POP_BACK,   '0, '0);
    send_item(OP_POP_FRONT,  '0, '0);
    send_item(OP_DUMP,       '0, '0);

    // Run full, dump the whole list, then drain.
    random_fill(34);
    send_item(OP_DUMP, '0, '0);
    random_items(30, 15, 40, 30, 8, 2);
    sender_burst = 1'b1;
    random_items(20, 40, 25, 20, 8, 2);
    sender_burst = 1'b0;
    random_items(15, 40, 25, 20, 8, 2);
    random_fill(34);
    send_item(OP_DUMP, '0, '0);
    random_items(20, 10, 40, 40, 8, 2);

    in_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (results_outstanding != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    // Give a stray late result time to show up.
    repeat (80) @(posedge clk);
    if (mismatch_total == 0 && results_outstanding == 0) begin
      $display("bounded_list_with_tail_unit verification clean");
    end else begin
      $display("bounded_list_with_tail_unit verification failed");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off that backs the block up,
  // and a stretch with the receiver always ready.
  initial begin
    int stall;
    int taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      if (taken == 30) begin
        stall = 300;
      end else if (taken >= 150 && taken < 230) begin
        stall = 0;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    #2_000_000;
    $display("bounded_list_with_tail_unit verification failed");
    $finish;
  end

endmodule

@@ files.f @@
design/blt_pkg.sv
design/blt_front.sv
design/blt_queue.sv
design/blt_back.sv
design/bounded_list_with_tail_unit.sv
tb/blt_list_checker.sv
tb/tb_bounded_list_with_tail_unit.sv
